/* hw/rtl/assert_macros.svh */
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define CPCP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on clk, off during rst.
`define CPCP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* hw/rtl/cpcp_pkg.sv */
// Package for the circle pair collision push block: beat types and constants.
package cpcp_pkg;

  // Clamp for the center distance, 4.0 in Q.8.
  localparam logic [16:0] MIN_DIST = 17'd1024;
  // Time step after reset, 1.0 in Q8.8.
  localparam logic [15:0] TIME_STEP_RESET = 16'd256;
  // Root width and radicand width of the square root.
  localparam int SQRT_RW = 17;
  localparam int SQRT_VW = 34;
  // Quotient bits produced by each divider.
  localparam int DIV_QW = 30;

  typedef struct packed {
    logic signed [23:0] first_x;
    logic signed [23:0] first_y;
    logic        [15:0] first_radius;
    logic        [15:0] first_mass;
    logic signed [23:0] second_x;
    logic signed [23:0] second_y;
    logic        [15:0] second_radius;
    logic        [15:0] second_mass;
  } in_t;

  typedef struct packed {
    logic               overlap;
    logic signed [23:0] first_dvx;
    logic signed [23:0] first_dvy;
    logic signed [23:0] second_dvx;
    logic signed [23:0] second_dvy;
  } out_t;

endpackage

/* hw/rtl/cpcp_sqrt.sv */
// Pipelined integer square root, one root bit per stage.
module cpcp_sqrt #(
  parameter int VW = cpcp_pkg::SQRT_VW,
  parameter int RW = cpcp_pkg::SQRT_RW,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          vld_in,
  input  logic [VW-1:0] radicand,
  input  logic [SW-1:0] side_in,
  output logic          vld_out,
  output logic [RW-1:0] root,
  output logic [SW-1:0] side_out
);

  logic [VW-1:0] rem   [RW+1];
  logic [RW-1:0] rt    [RW+1];
  logic [SW-1:0] side  [RW+1];
  logic          vld   [RW+1];

  assign rem[0]  = radicand;
  assign rt[0]   = '0;
  assign side[0] = side_in;
  assign vld[0]  = vld_in;

  // Try each root bit from the top; keep remainder = radicand - root^2.
  for (genvar k = 0; k < RW; k++) begin : g_stage
    localparam int I = RW - 1 - k;
    logic [VW:0] trial;
    assign trial = ((VW+1)'(rt[k]) << (I + 1)) + ((VW+1)'(1) << (2 * I));

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if ({1'b0, rem[k]} >= trial) begin
          rem[k+1] <= rem[k] - trial[VW-1:0];
          rt[k+1]  <= rt[k] | (RW'(1) << I);
        end else begin
          rem[k+1] <= rem[k];
          rt[k+1]  <= rt[k];
        end
        side[k+1] <= side[k];
      end
    end
  end

  assign vld_out  = vld[RW];
  assign root     = rt[RW];
  assign side_out = side[RW];

endmodule

/* hw/rtl/cpcp_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
module cpcp_div #(
  parameter int NW = 32,
  parameter int DW = 16,
  parameter int QW = cpcp_pkg::DIV_QW,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          vld_in,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] side_in,
  output logic          vld_out,
  output logic [QW-1:0] quot,
  output logic [SW-1:0] side_out
);

  localparam int WW = DW + QW;

  logic [NW-1:0] rem  [QW+1];
  logic [DW-1:0] dv   [QW+1];
  logic [QW-1:0] q    [QW+1];
  logic [SW-1:0] side [QW+1];
  logic          vld  [QW+1];

  assign rem[0]  = num;
  assign dv[0]   = den;
  assign q[0]    = '0;
  assign side[0] = side_in;
  assign vld[0]  = vld_in;

  // Subtract the shifted divisor where it fits, from the top quotient bit down.
  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int I = QW - 1 - k;
    logic [WW-1:0] rem_w;
    logic [WW-1:0] shd;
    logic [WW-1:0] diff;
    assign rem_w = WW'(rem[k]);
    assign shd   = WW'(dv[k]) << I;
    assign diff  = rem_w - shd;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_w >= shd) begin
          rem[k+1] <= diff[NW-1:0];
          q[k+1]   <= q[k] | (QW'(1) << I);
        end else begin
          rem[k+1] <= rem[k];
          q[k+1]   <= q[k];
        end
        dv[k+1]   <= dv[k];
        side[k+1] <= side[k];
      end
    end
  end

  assign vld_out  = vld[QW];
  assign quot     = q[QW];
  assign side_out = side[QW];

endmodule

/* hw/rtl/circle_pair_collision_push.sv */
// Top level: overlap test and mass-split repulsion for one pair of circles.
//
//   channel | direction | handshake           | payload
//   in      | input     | in_valid / in_stall | cpcp_pkg::in_t
//   out     | output    | out_valid/out_stall | cpcp_pkg::out_t
//   cfg     | input     | cfg_we              | cfg_data (time_step)
//
// One beat enters per cycle unless the pipeline is frozen. It has 3 setup stages,
// 17 square root stages, 1 clamp stage, 30 divider stages, 3 scaling stages.
// rst clears every valid bit and loads time_step with 1.0.
// out_stall freezes the whole pipeline while out_valid is high; in_stall is high exactly then.
module circle_pair_collision_push (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  cpcp_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output cpcp_pkg::out_t out_data,
  input  logic           cfg_we,
  input  logic [15:0]    cfg_data
);

  localparam int RW = cpcp_pkg::SQRT_RW;
  localparam int VW = cpcp_pkg::SQRT_VW;
  localparam int QW = cpcp_pkg::DIV_QW;

  typedef struct packed {
    logic        ovl;
    logic        sx;
    logic        sy;
    logic [16:0] adx;
    logic [16:0] ady;
    logic [32:0] mts;
    logic [15:0] m1;
    logic [15:0] m2;
  } sq_side_t;

  typedef struct packed {
    logic ovl;
  } pw_side_t;

  logic        en;
  logic [15:0] time_step;

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // Hold the time step register.
  always_ff @(posedge clk) begin
    if (rst) begin
      time_step <= cpcp_pkg::TIME_STEP_RESET;
    end else if (cfg_we) begin
      time_step <= cfg_data;
    end
  end

  // Stage 1: differences, magnitudes, radius sum.
  logic        v1;
  logic [24:0] dx1, dy1;
  logic [24:0] adx1, ady1;
  logic [16:0] meet1;
  logic [15:0] m1_1, m2_1;
  logic [24:0] dx_c, dy_c;

  assign dx_c = {in_data.first_x[23], in_data.first_x}
              - {in_data.second_x[23], in_data.second_x};
  assign dy_c = {in_data.first_y[23], in_data.first_y}
              - {in_data.second_y[23], in_data.second_y};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx1   <= dx_c;
      dy1   <= dy_c;
      adx1  <= dx_c[24] ? -dx_c : dx_c;
      ady1  <= dy_c[24] ? -dy_c : dy_c;
      meet1 <= {1'b0, in_data.first_radius} + {1'b0, in_data.second_radius};
      m1_1  <= in_data.first_mass;
      m2_1  <= in_data.second_mass;
    end
  end

  // Stage 2: squares and the radius-time product.
  logic        v2;
  logic [49:0] adx2_2, ady2_2;
  logic [33:0] msq2;
  logic [32:0] mts2;
  logic        sx2, sy2;
  logic [16:0] adx2, ady2;
  logic [15:0] m1_2, m2_2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      adx2_2 <= adx1 * adx1;
      ady2_2 <= ady1 * ady1;
      msq2   <= meet1 * meet1;
      mts2   <= meet1 * time_step;
      sx2    <= dx1[24];
      sy2    <= dy1[24];
      adx2   <= adx1[16:0];
      ady2   <= ady1[16:0];
      m1_2   <= m1_1;
      m2_2   <= m2_1;
    end
  end

  // Stage 3: squared distance and overlap test.
  logic        v3;
  logic [VW-1:0] dsq3;
  sq_side_t    sq_in;
  logic [49:0] dsq_c;

  assign dsq_c = adx2_2 + ady2_2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dsq3       <= dsq_c[VW-1:0];
      sq_in.ovl  <= dsq_c < {16'd0, msq2};
      sq_in.sx   <= sx2;
      sq_in.sy   <= sy2;
      sq_in.adx  <= adx2;
      sq_in.ady  <= ady2;
      sq_in.mts  <= mts2;
      sq_in.m1   <= m1_2;
      sq_in.m2   <= m2_2;
    end
  end

  // Square root of the squared distance.
  logic          v_sq;
  logic [RW-1:0] dist_sq;
  sq_side_t      sq_out;

  cpcp_sqrt #(
    .VW(VW),
    .RW(RW),
    .SW($bits(sq_side_t))
  ) u_sqrt (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .vld_in  (v3),
    .radicand(dsq3),
    .side_in (sq_in),
    .vld_out (v_sq),
    .root    (dist_sq),
    .side_out(sq_out)
  );

  // Stage 4: coincident centers push along +x; clamp the distance.
  logic        v4;
  logic [16:0] dist4;
  logic [16:0] adx4, ady4;
  logic        sx4, sy4, ovl4;
  logic [32:0] mts4;
  logic [15:0] m1_4, m2_4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v_sq;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dist4 <= (dist_sq < cpcp_pkg::MIN_DIST) ? cpcp_pkg::MIN_DIST : dist_sq;
      if (dist_sq == '0) begin
        adx4 <= cpcp_pkg::MIN_DIST;
        sx4  <= 1'b0;
      end else begin
        adx4 <= sq_out.adx;
        sx4  <= sq_out.sx;
      end
      ady4 <= sq_out.ady;
      sy4  <= sq_out.sy;
      ovl4 <= sq_out.ovl;
      mts4 <= sq_out.mts;
      m1_4 <= sq_out.m1;
      m2_4 <= sq_out.m2;
    end
  end

  // Four dividers in parallel: push power, mass ratio, unit x, unit y.
  logic          v_dv;
  logic [QW-1:0] power_q, rate_q, ux_q, uy_q;
  pw_side_t      pw_in, pw_out;
  logic [16:0]   msum4;
  logic          msum0_d, sx_d, sy_d;

  assign pw_in.ovl = ovl4;
  assign msum4     = {1'b0, m1_4} + {1'b0, m2_4};

  cpcp_div #(.NW(41), .DW(18), .QW(QW), .SW($bits(pw_side_t))) u_div_power (
    .clk(clk), .rst(rst), .en(en), .vld_in(v4),
    .num({mts4, 8'd0}), .den({dist4, 1'b0}), .side_in(pw_in),
    .vld_out(v_dv), .quot(power_q), .side_out(pw_out)
  );

  cpcp_div #(.NW(32), .DW(17), .QW(QW), .SW(1)) u_div_rate (
    .clk(clk), .rst(rst), .en(en), .vld_in(v4),
    .num({m1_4, 16'd0}), .den(msum4), .side_in(msum4 == '0),
    .vld_out(), .quot(rate_q), .side_out(msum0_d)
  );

  cpcp_div #(.NW(33), .DW(17), .QW(QW), .SW(1)) u_div_ux (
    .clk(clk), .rst(rst), .en(en), .vld_in(v4),
    .num({adx4, 16'd0}), .den(dist4), .side_in(sx4),
    .vld_out(), .quot(ux_q), .side_out(sx_d)
  );

  cpcp_div #(.NW(33), .DW(17), .QW(QW), .SW(1)) u_div_uy (
    .clk(clk), .rst(rst), .en(en), .vld_in(v4),
    .num({ady4, 16'd0}), .den(dist4), .side_in(sy4),
    .vld_out(), .quot(uy_q), .side_out(sy_d)
  );

  // Stage 5: split the power by mass ratio.
  logic        v5;
  logic [29:0] push1_5, push2_5;
  logic [16:0] ux5, uy5;
  logic        sx5, sy5, ovl5;
  logic [16:0] rate_c;
  logic [46:0] p1_c, p2_c;

  assign rate_c = msum0_d ? 17'd32768 : rate_q[16:0];
  assign p1_c   = power_q[29:0] * (17'd65536 - rate_c);
  assign p2_c   = power_q[29:0] * rate_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= v_dv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      push1_5 <= p1_c[45:16];
      push2_5 <= p2_c[45:16];
      ux5     <= ux_q[16:0];
      uy5     <= uy_q[16:0];
      sx5     <= sx_d;
      sy5     <= sy_d;
      ovl5    <= pw_out.ovl;
    end
  end

  // Stage 6: scale the unit vector by each push.
  logic        v6;
  logic [46:0] px1_6, py1_6, px2_6, py2_6;
  logic        sx6, sy6, ovl6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (en) begin
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px1_6 <= ux5 * push1_5;
      py1_6 <= uy5 * push1_5;
      px2_6 <= ux5 * push2_5;
      py2_6 <= uy5 * push2_5;
      sx6   <= sx5;
      sy6   <= sy5;
      ovl6  <= ovl5;
    end
  end

  // Round half up to Q.8, apply the sign, saturate to 24 bits.
  function automatic logic [23:0] signed_sat(input logic neg, input logic [46:0] prod);
    logic [47:0] sum;
    logic [23:0] mag;
    sum = {1'b0, prod} + 48'(24'h800000);
    mag = sum[47:24];
    if (!neg) begin
      signed_sat = mag[23] ? 24'h7FFFFF : mag;
    end else begin
      signed_sat = (mag > 24'h800000) ? 24'h800000 : -mag;
    end
  endfunction

  // Stage 7: output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.overlap <= ovl6;
      if (ovl6) begin
        out_data.first_dvx  <= signed_sat(sx6, px1_6);
        out_data.first_dvy  <= signed_sat(sy6, py1_6);
        out_data.second_dvx <= signed_sat(!sx6, px2_6);
        out_data.second_dvy <= signed_sat(!sy6, py2_6);
      end else begin
        out_data.first_dvx  <= '0;
        out_data.first_dvy  <= '0;
        out_data.second_dvx <= '0;
        out_data.second_dvy <= '0;
      end
    end
  end

endmodule

/* hw/rtl/cpcp_checker.sv */
// Port-level checker for the circle pair collision push block, with its bind.
`include "assert_macros.svh"

module cpcp_checker (
  input logic           clk,
  input logic           rst,
  input logic           in_stall,
  input logic           out_valid,
  input logic           out_stall,
  input cpcp_pkg::out_t out_data
);

  // A stalled result beat holds.
  `CPCP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

  // The input side stalls only behind a stalled result.
  `CPCP_ASSERT_IMP(a_in_stall, in_stall, out_valid && out_stall)

  // A miss carries no push.
  `CPCP_ASSERT_IMP(a_miss_zero, out_valid && !out_data.overlap,
                   out_data.first_dvx == '0 && out_data.first_dvy == '0 &&
                   out_data.second_dvx == '0 && out_data.second_dvy == '0)

  // A hit pushes the two bodies apart along x.
  `CPCP_ASSERT_IMP(a_opposite_x,
                   out_valid && out_data.overlap && out_data.first_dvx != '0 &&
                   out_data.second_dvx != '0,
                   out_data.first_dvx[23] != out_data.second_dvx[23])

endmodule

bind circle_pair_collision_push cpcp_checker u_cpcp_checker (.*);
